FILE: rtl/slnorm_pkg.sv
// ----------------------------------------------------------------------------
// slnorm_pkg
// Shared constants, types and helpers of the socket list normalizer.
// ----------------------------------------------------------------------------
package slnorm_pkg;

    localparam int TAG_SLOTS = 16;
    localparam int IDX_W     = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;
    localparam int CNT_W     = $clog2(TAG_SLOTS + 1);
    localparam int SLOT_W    = 4;
    localparam int PORT_W    = 16;
    localparam int S_TDATA_W = 168;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_BAD_TAG    = 3'd1,
        STAT_DUP_TAG    = 3'd2,
        STAT_BAD_INDEX  = 3'd3,
        STAT_TABLE_FULL = 3'd4
    } status_t;

    typedef enum logic {
        BS_LOOK,
        BS_COMMIT
    } back_state_t;

    // classified entry handed from the front to the back
    typedef struct packed {
        logic              first;
        logic              last;
        logic              tag_ok;
        logic [IDX_W-1:0]  tag_idx;
        logic              index_ok;
        logic [PORT_W-1:0] delta;
        logic              kind;
        logic [63:0]       hi;
        logic [63:0]       lo;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] socket_slot;
        logic [SLOT_W-1:0] address_slot;
        logic              address_added;
        logic [PORT_W-1:0] rebased_offset;
        logic [PORT_W-1:0] abs_port;
        logic              record_end;
    } result_t;

    function automatic logic [SLOT_W-1:0] to_slot(input logic [CNT_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[SLOT_W-1:0];
    endfunction

endpackage

FILE: rtl/slnorm_front.sv
// ----------------------------------------------------------------------------
// slnorm_front
// Accepts socket entries, classifies tag and address index, normalizes the
// address and holds the entries in a two-deep queue for the back end.
// ----------------------------------------------------------------------------
module slnorm_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tag, port_delta, src_addr_index, src_addr_count, addr_high, addr_low
    // (lowest bits first)
    input  logic [slnorm_pkg::S_TDATA_W-1:0] s_tdata,
    // first, addr_is_ip6 (lowest bit first)
    input  logic [slnorm_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                             s_tlast,
    output logic                             q_valid,
    input  logic                             q_ready,
    output slnorm_pkg::item_t                q_item
);
    import slnorm_pkg::*;

    localparam int Q_DEPTH = 2;

    logic [7:0]  tag;
    logic [7:0]  aidx;
    logic [7:0]  acnt;
    logic        kind;
    item_t       cls;

    item_t       q_mem_reg [Q_DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;

    assign tag  = s_tdata[7:0];
    assign aidx = s_tdata[31:24];
    assign acnt = s_tdata[39:32];
    assign kind = s_tuser[1];

    always_comb begin
        cls.first    = s_tuser[0];
        cls.last     = s_tlast;
        cls.tag_ok   = {1'b0, tag} < 9'(TAG_SLOTS);
        cls.tag_idx  = tag[IDX_W-1:0];
        cls.index_ok = aidx < acnt;
        cls.delta    = s_tdata[23:8];
        cls.kind     = kind;
        // IPv4 keeps only the low word
        cls.hi       = kind ? s_tdata[103:40] : 64'd0;
        cls.lo       = kind ? s_tdata[167:104] : {32'd0, s_tdata[135:104]};
    end

    assign s_tready = cnt_reg != 2'(Q_DEPTH);
    assign q_valid  = cnt_reg != 2'd0;
    assign q_item   = q_mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

FILE: rtl/slnorm_back.sv
// ----------------------------------------------------------------------------
// slnorm_back
// Looks the entry's address up in the address table, then commits slots,
// ports and table updates and loads the result register.
// ----------------------------------------------------------------------------
module slnorm_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  slnorm_pkg::item_t   q_item,
    output logic                r_valid,
    input  logic                r_ready,
    output slnorm_pkg::result_t r_data
);
    import slnorm_pkg::*;

    back_state_t       state_reg, state_next;
    item_t             work_reg, work_next;
    logic [TAG_SLOTS-1:0] hit_reg, hit_next;
    logic [TAG_SLOTS-1:0] tag_valid_reg, tag_valid_next;
    logic [CNT_W-1:0]  sock_cnt_reg, sock_cnt_next;
    logic [CNT_W-1:0]  addr_cnt_reg, addr_cnt_next;
    logic [PORT_W-1:0] run_port_reg, run_port_next;
    logic [PORT_W-1:0] pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic [63:0]       store_hi_reg [TAG_SLOTS];
    logic [63:0]       store_lo_reg [TAG_SLOTS];
    logic              store_kind_reg [TAG_SLOTS];
    logic              store_we;
    logic [IDX_W-1:0]  store_wa;

    logic              out_free;
    logic              pop;
    logic              commit;

    // ---------------- control ----------------
    assign out_free = !out_valid_reg || r_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BS_LOOK: begin
                if (q_valid) begin
                    state_next = BS_COMMIT;
                end
            end
            BS_COMMIT: begin
                if (out_free) begin
                    state_next = BS_LOOK;
                end
            end
            default: state_next = BS_LOOK;
        endcase
    end

    always_comb begin
        pop    = 1'b0;
        commit = 1'b0;
        case (state_reg)
            BS_LOOK:   pop    = q_valid;
            BS_COMMIT: commit = out_free;
            default: begin
                pop    = 1'b0;
                commit = 1'b0;
            end
        endcase
    end

    assign q_ready = state_reg == BS_LOOK;
    assign r_valid = out_valid_reg;
    assign r_data  = out_reg;

    // ---------------- lookup ----------------
    always_comb begin
        work_next = pop ? q_item : work_reg;
        hit_next  = hit_reg;
        if (pop) begin
            for (int i = 0; i < TAG_SLOTS; i++) begin
                hit_next[i] = !q_item.first && (CNT_W'(i) < addr_cnt_reg) &&
                              store_kind_reg[i] == q_item.kind &&
                              store_hi_reg[i] == q_item.hi &&
                              store_lo_reg[i] == q_item.lo;
            end
        end
    end

    // ---------------- commit ----------------
    always_comb begin
        logic [CNT_W-1:0]  base_sock;
        logic [CNT_W-1:0]  base_addr;
        logic [TAG_SLOTS-1:0] base_tv;
        logic [PORT_W-1:0] rp;
        logic [PORT_W-1:0] pd;
        logic [CNT_W-1:0]  hit_slot;
        logic              dup;
        status_t           st;
        logic              add;

        base_sock = work_reg.first ? '0 : sock_cnt_reg;
        base_addr = work_reg.first ? '0 : addr_cnt_reg;
        base_tv   = work_reg.first ? '0 : tag_valid_reg;
        rp        = (work_reg.first ? '0 : run_port_reg) + work_reg.delta;
        pd        = (work_reg.first ? '0 : pend_reg) + work_reg.delta;
        dup       = work_reg.tag_ok && base_tv[work_reg.tag_idx];

        // lowest matching entry wins
        hit_slot = '0;
        for (int i = TAG_SLOTS - 1; i >= 0; i--) begin
            if (hit_reg[i]) begin
                hit_slot = CNT_W'(i);
            end
        end

        add = 1'b0;
        if (!work_reg.tag_ok) begin
            st = STAT_BAD_TAG;
        end else if (dup) begin
            st = STAT_DUP_TAG;
        end else if (!work_reg.index_ok) begin
            st = STAT_BAD_INDEX;
        end else if (|hit_reg) begin
            st = STAT_OK;
        end else if (base_addr == CNT_W'(TAG_SLOTS)) begin
            st = STAT_TABLE_FULL;
        end else begin
            st  = STAT_OK;
            add = 1'b1;
        end

        out_next.status         = st;
        out_next.socket_slot    = (st == STAT_OK) ? to_slot(base_sock) : '0;
        out_next.address_slot   = (st != STAT_OK) ? '0 :
                                  add ? to_slot(base_addr) : to_slot(hit_slot);
        out_next.address_added  = add;
        out_next.rebased_offset = (st == STAT_OK) ? pd : '0;
        out_next.abs_port       = rp;
        out_next.record_end     = work_reg.last;

        store_we = commit && add;
        store_wa = base_addr[IDX_W-1:0];

        tag_valid_next = tag_valid_reg;
        sock_cnt_next  = sock_cnt_reg;
        addr_cnt_next  = addr_cnt_reg;
        run_port_next  = run_port_reg;
        pend_next      = pend_reg;
        if (commit) begin
            tag_valid_next = base_tv;
            if (st == STAT_OK) begin
                tag_valid_next[work_reg.tag_idx] = 1'b1;
            end
            sock_cnt_next = base_sock + CNT_W'(st == STAT_OK);
            addr_cnt_next = base_addr + CNT_W'(add);
            run_port_next = rp;
            pend_next     = (st == STAT_OK) ? '0 : pd;
        end

        if (commit) begin
            out_valid_next = 1'b1;
        end else if (r_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BS_LOOK;
            tag_valid_reg <= '0;
            sock_cnt_reg  <= '0;
            addr_cnt_reg  <= '0;
            run_port_reg  <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tag_valid_reg <= tag_valid_next;
            sock_cnt_reg  <= sock_cnt_next;
            addr_cnt_reg  <= addr_cnt_next;
            run_port_reg  <= run_port_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        hit_reg  <= hit_next;
        if (commit) begin
            out_reg <= out_next;
        end
        if (store_we) begin
            store_hi_reg[store_wa]   <= work_reg.hi;
            store_lo_reg[store_wa]   <= work_reg.lo;
            store_kind_reg[store_wa] <= work_reg.kind;
        end
    end

endmodule

FILE: rtl/socket_list_normalizer_core.sv
// ----------------------------------------------------------------------------
// socket_list_normalizer_core
// Normalizes the socket entries of a peer record, one entry per transfer.
//
// Input channel s_*: one socket entry per transfer; s_tuser bit 0 marks the
// first entry of a record (clears slots, address table, running port and
// offset), s_tuser bit 1 gives the address kind, s_tlast marks the final one.
// Output channel m_*: one result per entry, in order; m_tlast copies last.
// The back end takes one entry at a time: a lookup state compares the entry
// against all address table entries, then a commit state commits slots, ports
// and table writes. An entry passes the queue, the lookup registers and the
// output register on its way to m_tvalid.
// A two-entry queue sits between classification and the back end, and the
// result sits in an output register, so input transfers continue while a
// result waits. When m_tready stays low the back end holds its entry, the
// queue fills and s_tready drops.
// Reset (aresetn low, synchronous) empties queue and output register and
// clears all per-record state.
// ----------------------------------------------------------------------------
module socket_list_normalizer_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tag, port_delta, src_addr_index, src_addr_count, addr_high, addr_low
    // (lowest bits first)
    input  logic [slnorm_pkg::S_TDATA_W-1:0] s_tdata,
    // first, addr_is_ip6 (lowest bit first)
    input  logic [slnorm_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status, socket_slot, address_slot, address_added, rebased_offset,
    // abs_port (lowest bits first), zero padded
    output logic [slnorm_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                             m_tlast
);
    import slnorm_pkg::*;

    logic    q_valid;
    logic    q_ready;
    item_t   q_item;
    result_t res;

    slnorm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    slnorm_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .r_valid (m_tvalid),
        .r_ready (m_tready),
        .r_data  (res)
    );

    assign m_tdata = {4'd0, res.abs_port, res.rebased_offset, res.address_added,
                      res.address_slot, res.socket_slot, res.status};
    assign m_tlast = res.record_end;

    // rejected entries carry no slots, no added flag and no offset
    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.status != STAT_OK |->
            res.socket_slot == '0 && res.address_slot == '0 &&
            !res.address_added && res.rebased_offset == '0)
        else $error("rejected entry carries slot or offset data");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res.status == STAT_OK || res.status == STAT_BAD_TAG ||
                     res.status == STAT_DUP_TAG || res.status == STAT_BAD_INDEX ||
                     res.status == STAT_TABLE_FULL)
        else $error("status code out of range");

    a_added_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.address_added |-> res.status == STAT_OK)
        else $error("address added for a rejected entry");

endmodule
